### design/dda_grid_ray_cast_macros.svh
// assertion helpers shared by the ray caster rtl
`ifndef DDA_GRID_RAY_CAST_MACROS_SVH
`define DDA_GRID_RAY_CAST_MACROS_SVH

// same-cycle implication, checked out of reset
`define DGRC_CHK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DGRC_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dgrc_pkg.sv
package dgrc_pkg;

    localparam int POS_W   = 13;
    localparam int VEC_W   = 16;
    localparam int RAY_W   = 19;
    localparam int MAG_W   = 18;
    localparam int DELTA_W = 31;
    localparam int FRAC_W  = 9;
    localparam int SIDE_W  = 50;
    localparam int DIST_W  = 32;
    localparam int CELL_W  = 5;
    localparam int VAL_W   = 8;
    localparam int IDX_W   = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_POS_X   = 3'd0;
    localparam logic [IDX_W-1:0] REG_POS_Y   = 3'd1;
    localparam logic [IDX_W-1:0] REG_DIR_X   = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIR_Y   = 3'd3;
    localparam logic [IDX_W-1:0] REG_PLANE_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_PLANE_Y = 3'd5;

    // side codes
    localparam logic [1:0] SIDE_EAST  = 2'd0;
    localparam logic [1:0] SIDE_WEST  = 2'd1;
    localparam logic [1:0] SIDE_NORTH = 2'd2;
    localparam logic [1:0] SIDE_SOUTH = 2'd3;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CAST  = 1'b1;

    typedef logic [SIDE_W-1:0] side_dist_t;

endpackage

### design/dda_grid_ray_cast.sv
// a cast runs ray setup, then the reciprocal for each axis, then boundary setup, then for
//   each map step a step state and a registered map read, then distance and result output
// a write beat is written to the map as it is accepted; one item at a time, s_ready low while a cast runs
// the shared divider (one quotient bit a cycle) and the single map read port set the rate
// reset: synchronous active-low aresetn restores register defaults and then clears the map,
//   one cell a cycle over all 2^(2*clog2(MAP_SIDE)) cells with s_ready low
`include "dda_grid_ray_cast_macros.svh"

module dda_grid_ray_cast
    import dgrc_pkg::*;
#(
    parameter int MAP_SIDE  = 32,
    parameter int MAX_STEPS = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration writes
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [VEC_W-1:0]        cfg_data,
    // input beats
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_mode,
    input  logic [CELL_W-1:0]       s_cell_x,
    input  logic [CELL_W-1:0]       s_cell_y,
    input  logic [VAL_W-1:0]        s_cell_value,
    input  logic signed [VEC_W-1:0] s_camera_x,
    // result beats
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [CELL_W-1:0]       m_hit_x,
    output logic [CELL_W-1:0]       m_hit_y,
    output logic [VAL_W-1:0]        m_wall_type,
    output logic [1:0]              m_side,
    output logic [DIST_W-1:0]       m_distance,
    output logic                    m_no_hit
);

    // map geometry: coordinates carry one spare bit so a step below zero wraps high
    localparam int CW    = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1;
    localparam int MW    = CW + 1;
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int SCW   = $clog2(MAX_STEPS + 1);
    localparam int EXW   = 9;
    localparam int DCW   = $clog2(DELTA_W);

    // sequencer codes
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RAYX = 4'd1;
    localparam logic [3:0] ST_RAYY = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_SETX = 4'd4;
    localparam logic [3:0] ST_SETY = 4'd5;
    localparam logic [3:0] ST_STEP = 4'd6;
    localparam logic [3:0] ST_CHK  = 4'd7;
    localparam logic [3:0] ST_DIST = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    // configuration registers
    logic [POS_W-1:0]        pos_x_reg, pos_y_reg;
    logic signed [VEC_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= 13'd4224;
            pos_y_reg   <= 13'd4224;
            dir_x_reg   <= -16'sd16384;
            dir_y_reg   <= 16'sd0;
            plane_x_reg <= 16'sd0;
            plane_y_reg <= 16'sd10813;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_POS_X:   pos_x_reg   <= cfg_data[POS_W-1:0];
                REG_POS_Y:   pos_y_reg   <= cfg_data[POS_W-1:0];
                REG_DIR_X:   dir_x_reg   <= cfg_data;
                REG_DIR_Y:   dir_y_reg   <= cfg_data;
                REG_PLANE_X: plane_x_reg <= cfg_data;
                REG_PLANE_Y: plane_y_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer and datapath registers
    logic [3:0]              state_reg, state_next;
    logic signed [VEC_W-1:0] cam_reg, cam_next;
    logic [MAG_W-1:0]        mag_x_reg, mag_x_next, mag_y_reg, mag_y_next;
    logic                    neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic                    inf_x_reg, inf_x_next, inf_y_reg, inf_y_next;
    logic [DELTA_W-1:0]      dx_reg, dx_next, dy_reg, dy_next;
    logic                    div_axis_reg, div_axis_next;
    logic [DCW-1:0]          div_cnt_reg, div_cnt_next;
    logic [MAG_W:0]          rem_reg, rem_next;
    logic [DELTA_W-1:0]      quo_reg, quo_next;
    side_dist_t              ax_reg, ax_next, ay_reg, ay_next;
    logic [MW-1:0]           mx_reg, mx_next, my_reg, my_next;
    logic [1:0]              side_reg, side_next;
    logic [SCW-1:0]          step_cnt_reg, step_cnt_next;
    logic [VAL_W-1:0]        wall_reg, wall_next;
    logic                    nohit_reg, nohit_next;
    logic [DIST_W-1:0]       dist_reg, dist_next;

    // result register
    logic                    m_valid_reg, m_valid_next;
    logic [CELL_W-1:0]       m_hit_x_reg, m_hit_x_next, m_hit_y_reg, m_hit_y_next;
    logic [VAL_W-1:0]        m_wall_reg, m_wall_next;
    logic [1:0]              m_side_reg, m_side_next;
    logic [DIST_W-1:0]       m_dist_reg, m_dist_next;
    logic                    m_nohit_reg, m_nohit_next;

    // map store with clearing pass
    logic [VAL_W-1:0]        map_mem [DEPTH];
    logic [VAL_W-1:0]        map_rdata_reg;
    logic                    clr_busy_reg;
    logic [AW-1:0]           clr_addr_reg;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr, mem_raddr;
    logic [VAL_W-1:0]        mem_wdata;

    // shared multiplier and helpers
    logic signed [VEC_W-1:0]   mul_a;
    logic signed [2*VEC_W-1:0] ray_prod;
    logic signed [RAY_W-1:0]   ray_sum;
    logic [POS_W-1:0]          set_pos;
    logic                      set_neg;
    logic [FRAC_W-1:0]         set_frac;
    logic [DELTA_W-1:0]        set_delta;
    logic [MAG_W-1:0]          div_mag;
    logic                      div_inf;
    logic [MAG_W:0]            rem_sh;
    logic                      rem_ge;
    logic                      take_x;
    logic [MW-1:0]             nmx, nmy;
    side_dist_t                dist_diff;
    logic                      accept_in, write_ok, start_in, out_load;
    logic [EXW-1:0]            wr_x_ext, wr_y_ext, st_x_ext, st_y_ext, hx_ext, hy_ext;

    assign accept_in = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE) && !clr_busy_reg;

    assign wr_x_ext = EXW'(s_cell_x);
    assign wr_y_ext = EXW'(s_cell_y);
    assign write_ok = (wr_x_ext < EXW'(MAP_SIDE)) && (wr_y_ext < EXW'(MAP_SIDE));
    assign st_x_ext = EXW'(pos_x_reg[POS_W-1:8]);
    assign st_y_ext = EXW'(pos_y_reg[POS_W-1:8]);
    assign start_in = (st_x_ext < EXW'(MAP_SIDE)) && (st_y_ext < EXW'(MAP_SIDE));

    assign mem_we    = clr_busy_reg || (accept_in && (s_mode == MODE_WRITE) && write_ok);
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : {wr_x_ext[CW-1:0], wr_y_ext[CW-1:0]};
    assign mem_wdata = clr_busy_reg ? '0 : s_cell_value;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        map_rdata_reg <= map_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // ray component: dir + floor(plane * cam / 2^14)
    assign mul_a    = (state_reg == ST_RAYX) ? plane_x_reg : plane_y_reg;
    assign ray_prod = mul_a * cam_reg;
    assign ray_sum  = RAY_W'((state_reg == ST_RAYX) ? dir_x_reg : dir_y_reg)
                    + RAY_W'(ray_prod >>> 14);

    // restoring divider for 2^30 / |ray|, one quotient bit a cycle
    assign div_mag = div_axis_reg ? mag_y_reg : mag_x_reg;
    assign div_inf = div_axis_reg ? inf_y_reg : inf_x_reg;
    assign rem_sh  = {rem_reg[MAG_W-1:0], (div_cnt_reg == DCW'(DELTA_W - 1))};
    assign rem_ge  = rem_sh >= {1'b0, div_mag};

    // first boundary distance: frac * delta
    assign set_pos   = (state_reg == ST_SETX) ? pos_x_reg : pos_y_reg;
    assign set_neg   = (state_reg == ST_SETX) ? neg_x_reg : neg_y_reg;
    assign set_delta = (state_reg == ST_SETX) ? dx_reg : dy_reg;
    assign set_frac  = set_neg ? FRAC_W'(set_pos[7:0]) : (9'd256 - FRAC_W'(set_pos[7:0]));

    // one dda step: nearer boundary wins, y on a tie
    assign take_x    = !inf_x_reg && (inf_y_reg || (ax_reg < ay_reg));
    assign nmx       = take_x ? (neg_x_reg ? mx_reg - 1'b1 : mx_reg + 1'b1) : mx_reg;
    assign nmy       = take_x ? my_reg : (neg_y_reg ? my_reg - 1'b1 : my_reg + 1'b1);
    assign mem_raddr = {nmx[CW-1:0], nmy[CW-1:0]};

    assign dist_diff = (side_reg == SIDE_EAST || side_reg == SIDE_WEST)
                     ? ax_reg - SIDE_W'({dx_reg, 8'd0})
                     : ay_reg - SIDE_W'({dy_reg, 8'd0});

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next    = state_reg;
        cam_next      = cam_reg;
        mag_x_next    = mag_x_reg;
        mag_y_next    = mag_y_reg;
        neg_x_next    = neg_x_reg;
        neg_y_next    = neg_y_reg;
        inf_x_next    = inf_x_reg;
        inf_y_next    = inf_y_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        div_axis_next = div_axis_reg;
        div_cnt_next  = div_cnt_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        side_next     = side_reg;
        step_cnt_next = step_cnt_reg;
        wall_next     = wall_reg;
        nohit_next    = nohit_reg;
        dist_next     = dist_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept_in && (s_mode != MODE_WRITE)) begin
                    cam_next   = s_camera_x;
                    state_next = ST_RAYX;
                end
            end
            ST_RAYX: begin
                neg_x_next = ray_sum[RAY_W-1];
                mag_x_next = MAG_W'(ray_sum[RAY_W-1] ? -ray_sum : ray_sum);
                inf_x_next = (ray_sum == '0);
                state_next = ST_RAYY;
            end
            ST_RAYY: begin
                neg_y_next    = ray_sum[RAY_W-1];
                mag_y_next    = MAG_W'(ray_sum[RAY_W-1] ? -ray_sum : ray_sum);
                inf_y_next    = (ray_sum == '0);
                div_axis_next = 1'b0;
                div_cnt_next  = DCW'(DELTA_W - 1);
                rem_next      = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                rem_next = rem_ge ? rem_sh - {1'b0, div_mag} : rem_sh;
                quo_next = {quo_reg[DELTA_W-2:0], rem_ge};
                if (div_inf || (div_cnt_reg == '0)) begin
                    // infinite step is held as zero and never used
                    if (div_axis_reg) begin
                        dy_next    = div_inf ? '0 : quo_next;
                        state_next = ST_SETX;
                    end else begin
                        dx_next = div_inf ? '0 : quo_next;
                    end
                    div_axis_next = 1'b1;
                    div_cnt_next  = DCW'(DELTA_W - 1);
                    rem_next      = '0;
                end else begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            ST_SETX: begin
                ax_next    = SIDE_W'(set_frac) * SIDE_W'(set_delta);
                state_next = ST_SETY;
            end
            ST_SETY: begin
                ay_next       = SIDE_W'(set_frac) * SIDE_W'(set_delta);
                mx_next       = MW'(st_x_ext);
                my_next       = MW'(st_y_ext);
                step_cnt_next = '0;
                if (start_in) begin
                    state_next = ST_STEP;
                end else begin
                    nohit_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_STEP: begin
                mx_next = nmx;
                my_next = nmy;
                if (take_x) begin
                    ax_next   = ax_reg + SIDE_W'({dx_reg, 8'd0});
                    side_next = neg_x_reg ? SIDE_EAST : SIDE_WEST;
                end else begin
                    if (!inf_y_reg) begin
                        ay_next = ay_reg + SIDE_W'({dy_reg, 8'd0});
                    end
                    side_next = neg_y_reg ? SIDE_NORTH : SIDE_SOUTH;
                end
                // a step below zero wraps above the map edge
                if ((nmx >= MW'(MAP_SIDE)) || (nmy >= MW'(MAP_SIDE))) begin
                    nohit_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (map_rdata_reg != '0) begin
                    wall_next  = map_rdata_reg;
                    nohit_next = 1'b0;
                    state_next = ST_DIST;
                end else if (step_cnt_reg == SCW'(MAX_STEPS - 1)) begin
                    nohit_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    step_cnt_next = step_cnt_reg + 1'b1;
                    state_next    = ST_STEP;
                end
            end
            ST_DIST: begin
                if (((side_reg == SIDE_NORTH) || (side_reg == SIDE_SOUTH)) && inf_y_reg) begin
                    dist_next = '1;
                end else if (|dist_diff[SIDE_W-1:DIST_W+8]) begin
                    dist_next = '1;
                end else begin
                    dist_next = dist_diff[DIST_W+7:8];
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    nohit_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result fields, zero on a miss
    assign hx_ext = EXW'(mx_reg);
    assign hy_ext = EXW'(my_reg);

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_hit_x_next = m_hit_x_reg;
        m_hit_y_next = m_hit_y_reg;
        m_wall_next  = m_wall_reg;
        m_side_next  = m_side_reg;
        m_dist_next  = m_dist_reg;
        m_nohit_next = m_nohit_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_nohit_next = nohit_reg;
            m_hit_x_next = nohit_reg ? '0 : hx_ext[CELL_W-1:0];
            m_hit_y_next = nohit_reg ? '0 : hy_ext[CELL_W-1:0];
            m_wall_next  = nohit_reg ? '0 : wall_reg;
            m_side_next  = nohit_reg ? '0 : side_reg;
            m_dist_next  = nohit_reg ? '0 : dist_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            nohit_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            nohit_reg   <= nohit_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        cam_reg      <= cam_next;
        mag_x_reg    <= mag_x_next;
        mag_y_reg    <= mag_y_next;
        neg_x_reg    <= neg_x_next;
        neg_y_reg    <= neg_y_next;
        inf_x_reg    <= inf_x_next;
        inf_y_reg    <= inf_y_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        div_axis_reg <= div_axis_next;
        div_cnt_reg  <= div_cnt_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        side_reg     <= side_next;
        step_cnt_reg <= step_cnt_next;
        wall_reg     <= wall_next;
        dist_reg     <= dist_next;
        m_hit_x_reg  <= m_hit_x_next;
        m_hit_y_reg  <= m_hit_y_next;
        m_wall_reg   <= m_wall_next;
        m_side_reg   <= m_side_next;
        m_dist_reg   <= m_dist_next;
        m_nohit_reg  <= m_nohit_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_hit_x     = m_hit_x_reg;
    assign m_hit_y     = m_hit_y_reg;
    assign m_wall_type = m_wall_reg;
    assign m_side      = m_side_reg;
    assign m_distance  = m_dist_reg;
    assign m_no_hit    = m_nohit_reg;

    `DGRC_CHK(a_miss_is_zero, m_valid && m_no_hit,
              (m_distance == '0) && (m_wall_type == '0), "miss result carries nonzero fields")
    `DGRC_CHK(a_hit_nonempty, m_valid && !m_no_hit, m_wall_type != '0,
              "hit reported on an empty cell")
    `DGRC_CHK(a_step_bound, state_reg == ST_CHK, step_cnt_reg < SCW'(MAX_STEPS),
              "step count passed the limit")
    `DGRC_CHK(a_ready_after_clear, s_ready, !clr_busy_reg, "input taken during map clear")
    `DGRC_CHK_NEXT(a_load_shows, out_load, m_valid, "loaded result not presented")

endmodule
